@@ rtl/olid_pkg.sv @@
// shared types, codes and ring address helpers for the ordered list block
package olid_pkg;

    localparam int LIST_CAPACITY = 32;
    localparam int VALUE_W       = 32;
    localparam int IDX_W         = $clog2(LIST_CAPACITY);
    localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [IDX_W:0]     idx_sum_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [VALUE_W-1:0] value_t;

    // request codes
    localparam logic [1:0] ACT_FRONT  = 2'd0;
    localparam logic [1:0] ACT_BACK   = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam cnt_t LIST_FULL = cnt_t'(LIST_CAPACITY);

    // ring add, both operands below the capacity
    function automatic idx_t wrap_add(input idx_t a, input idx_t b);
        idx_sum_t sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= idx_sum_t'(LIST_CAPACITY)) begin
                sum = sum - idx_sum_t'(LIST_CAPACITY);
            end
            return idx_t'(sum);
        end
    endfunction

    function automatic idx_t wrap_inc(input idx_t a);
        return (a == idx_t'(LIST_CAPACITY - 1)) ? '0 : a + idx_t'(1);
    endfunction

    function automatic idx_t wrap_dec(input idx_t a);
        return (a == '0) ? idx_t'(LIST_CAPACITY - 1) : a - idx_t'(1);
    endfunction

endpackage

@@ rtl/olid_ram.sv @@
// generic simple dual port ram with registered read
module olid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ordered_list_with_indexed_delete.sv @@
// ordered list of signed values with front insert, back append, indexed delete
//
// channel | dir | fields (lowest bit first)
// --------+-----+--------------------------------------------------------------
// s_axis  | in  | tdata: action[1:0], operand[33:2], zero pad [39:34]
// m_axis  | out | tdata: item_value[31:0]; tlast: last_item;
//         |     | tuser: list_empty[0], insert_refused[1]
//
// sequence: one transfer in, then the listing starts; each listed entry takes a
//   ram read and an output load, and an empty list gives a single zero result;
//   a delete first moves each entry behind the deleted position down one slot,
//   a ram read then a ram write per entry. the single ram read port serialises
//   these steps. reset: head pointer and entry count clear at once, no pass over the ram
// stalls: s_axis_tready is high only when idle; m_axis_tready low holds the
//   current result transfer and the walk through the list

module ordered_list_with_indexed_delete (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action[1:0], operand[33:2], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // item_value[31:0]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // list_empty[0], insert_refused[1]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_LOAD,
        S_LIST_OUT
    } state_t;

    state_t state_reg, state_next;

    // ring buffer bookkeeping
    olid_pkg::idx_t   head_reg, head_next;
    olid_pkg::cnt_t   count_reg, count_next;
    olid_pkg::idx_t   cur_reg, cur_next;      // physical slot being walked
    olid_pkg::cnt_t   left_reg, left_next;    // moves or listed entries still to go
    logic             refused_reg, refused_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    olid_pkg::value_t m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_empty_reg, m_empty_next;

    // ram port
    logic             ram_wr_en;
    olid_pkg::idx_t   ram_wr_addr;
    olid_pkg::value_t ram_wr_data;
    logic             ram_rd_en;
    olid_pkg::idx_t   ram_rd_addr;
    olid_pkg::value_t ram_rd_data;

    // input fields
    logic [1:0]         in_action;
    logic signed [31:0] in_operand;
    logic               s_xfer;
    logic               del_ok;
    olid_pkg::cnt_t     del_left;

    assign in_action  = s_axis_tdata[1:0];
    assign in_operand = s_axis_tdata[33:2];
    assign s_xfer     = s_axis_tvalid && s_axis_tready;

    // negative positions look huge when taken unsigned
    assign del_ok   = $unsigned(in_operand) < 32'(count_reg);
    assign del_left = count_reg - olid_pkg::cnt_t'(in_operand) - olid_pkg::cnt_t'(1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {refused_reg, m_empty_reg};

    olid_ram #(
        .WIDTH (olid_pkg::VALUE_W),
        .DEPTH (olid_pkg::LIST_CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        refused_next = refused_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_empty_next = m_empty_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = cur_reg;
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = cur_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    refused_next = 1'b0;
                    cur_next     = head_reg;
                    state_next   = S_LIST_RD;
                    unique case (in_action)
                        olid_pkg::ACT_FRONT, olid_pkg::ACT_BACK: begin
                            if (count_reg == olid_pkg::LIST_FULL) begin
                                refused_next = 1'b1;
                            end else if (in_action == olid_pkg::ACT_FRONT) begin
                                // new front goes one slot below the old head
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = olid_pkg::wrap_dec(head_reg);
                                ram_wr_data = in_operand;
                                head_next   = olid_pkg::wrap_dec(head_reg);
                                cur_next    = olid_pkg::wrap_dec(head_reg);
                                count_next  = count_reg + olid_pkg::cnt_t'(1);
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = olid_pkg::wrap_add(head_reg,
                                                  olid_pkg::idx_t'(count_reg));
                                ram_wr_data = in_operand;
                                count_next  = count_reg + olid_pkg::cnt_t'(1);
                            end
                        end
                        olid_pkg::ACT_DELETE: begin
                            if (del_ok) begin
                                count_next = count_reg - olid_pkg::cnt_t'(1);
                                left_next  = del_left;
                                if (del_left != '0) begin
                                    // close the gap by pulling the tail down
                                    cur_next   = olid_pkg::wrap_add(head_reg,
                                                     olid_pkg::idx_t'(in_operand));
                                    state_next = S_DEL_RD;
                                end
                            end
                        end
                        default: begin
                            // unused code: list only
                        end
                    endcase
                end
            end
            S_DEL_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = olid_pkg::wrap_inc(cur_reg);
                state_next  = S_DEL_WR;
            end
            S_DEL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg;
                ram_wr_data = ram_rd_data;
                left_next   = left_reg - olid_pkg::cnt_t'(1);
                if (left_reg == olid_pkg::cnt_t'(1)) begin
                    cur_next   = head_reg;
                    state_next = S_LIST_RD;
                end else begin
                    cur_next   = olid_pkg::wrap_inc(cur_reg);
                    state_next = S_DEL_RD;
                end
            end
            S_LIST_RD: begin
                left_next = count_reg;
                if (count_reg == '0) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    m_empty_next = 1'b1;
                    state_next   = S_LIST_OUT;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg;
                    state_next  = S_LIST_LOAD;
                end
            end
            S_LIST_LOAD: begin
                m_valid_next = 1'b1;
                m_data_next  = ram_rd_data;
                m_last_next  = (left_reg == olid_pkg::cnt_t'(1));
                m_empty_next = 1'b0;
                state_next   = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (m_axis_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = olid_pkg::wrap_inc(cur_reg);
                        cur_next    = olid_pkg::wrap_inc(cur_reg);
                        left_next   = left_reg - olid_pkg::cnt_t'(1);
                        state_next  = S_LIST_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            cur_reg     <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
            refused_reg <= refused_next;
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
            m_empty_reg <= m_empty_next;
        end
    end

endmodule

@@ rtl/olid_checker.sv @@
// port-level checks for the ordered list block, bound to the top level
module olid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // no new request while a result is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // the input is not ready in the cycle after a request is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a request transfer");

    // the empty listing is a single zero result
    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("empty result not last or not zero");

    // the listing's final transfer frees the input side
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not ready after the last result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind ordered_list_with_indexed_delete olid_checker u_olid_checker (.*);
